// ===== sv/srx_pkg.sv =====
// Shared types, constants and the CRC-8 step for the serial packet receiver.
`default_nettype none
package srx_pkg;

  localparam logic [7:0] SyncByte   = 8'h55;
  localparam logic [7:0] HdrTeachIn = 8'h62;
  localparam logic [7:0] HdrRps     = 8'h20;
  localparam logic [7:0] Hdr1bs     = 8'h21;
  localparam logic [7:0] Hdr4bs     = 8'h22;
  localparam logic [7:0] HdrVld     = 8'h24;
  localparam logic [7:0] CrcPoly    = 8'h07;
  localparam logic [7:0] NibbleMask = 8'h0F;
  localparam logic [7:0] RadioReset = 8'h01;
  localparam logic [7:0] Erp2Reset  = 8'h0A;
  localparam logic [7:0] RespReset  = 8'h02;

  localparam int CapDepth = 11;
  localparam int PosW     = 17;
  localparam int TdataW   = 120;

  // config register indexes
  localparam logic [1:0] CfgRadio = 2'd0;
  localparam logic [1:0] CfgErp2  = 2'd1;
  localparam logic [1:0] CfgResp  = 2'd2;

  // result status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StHdrCrc  = 2'd1;
  localparam logic [1:0] StDataCrc = 2'd2;
  localparam logic [1:0] StUnknown = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEADER,
    PH_HCRC,
    PH_BODY,
    PH_DCRC
  } srx_phase_e;

  // Frame as seen at the closing CRC byte
  typedef struct packed {
    logic [7:0]                ptype;
    logic [15:0]               dlen;
    logic [7:0]                olen;
    logic [CapDepth-1:0][7:0]  cap;
    logic                      crc_ok;
    logic                      hdr_bad;
  } srx_frame_t;

  typedef struct packed {
    logic [31:0] payload;
    logic [31:0] sender_id;
    logic [7:0]  telegram_header;
    logic [7:0]  response_code;
    logic        is_response;
    logic        is_radio;
    logic [7:0]  option_length;
    logic [15:0] data_length;
    logic [7:0]  packet_type;
    logic [1:0]  status;
  } srx_result_t;

  typedef struct packed {
    logic [7:0] radio;
    logic [7:0] erp2;
    logic [7:0] resp;
  } srx_cfg_t;

  // One byte through CRC-8, MSB first, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/srx_frame.sv =====
// Frame tracker: sync hunt, header capture, body count and running CRC-8.
`default_nettype none
module srx_frame (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                acc_i,
  input  wire logic [7:0]          byte_i,
  output logic                     done_o,
  output srx_pkg::srx_frame_t      frame_o
);
  import srx_pkg::*;

  srx_phase_e               phase_q, phase_d;
  logic [1:0]               hidx_q, hidx_d;
  logic [3:0][7:0]          hdr_q, hdr_d;
  logic [7:0]               hcrc_q, hcrc_d;
  logic [PosW-1:0]          pos_q, pos_d;
  logic [7:0]               crc_q, crc_d;
  logic [CapDepth-1:0][7:0] cap_q, cap_d;
  logic                     hbad_q, hbad_d;

  logic [15:0]     dlen;
  logic [PosW-1:0] blen;
  logic [PosW-1:0] pos_inc;

  assign dlen    = {hdr_q[0], hdr_q[1]};
  assign blen    = {1'b0, dlen} + {{(PosW-8){1'b0}}, hdr_q[2]};
  assign pos_inc = pos_q + {{(PosW-1){1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hidx_q <= '0;
      hdr_q  <= '0;
      hcrc_q <= '0;
      pos_q  <= '0;
      crc_q  <= '0;
      cap_q  <= '0;
      hbad_q <= 1'b0;
    end else begin
      hidx_q <= hidx_d;
      hdr_q  <= hdr_d;
      hcrc_q <= hcrc_d;
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      cap_q  <= cap_d;
      hbad_q <= hbad_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    hidx_d  = hidx_q;
    hdr_d   = hdr_q;
    hcrc_d  = hcrc_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    cap_d   = cap_q;
    hbad_d  = hbad_q;
    done_o  = 1'b0;
    if (acc_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (byte_i == SyncByte) begin
            phase_d = PH_HEADER;
            hidx_d  = '0;
            hcrc_d  = '0;
            cap_d   = '0;
            hbad_d  = 1'b0;
            pos_d   = '0;
            crc_d   = '0;
          end
        end
        PH_HEADER: begin
          hdr_d[hidx_q] = byte_i;
          hcrc_d        = crc8_byte(hcrc_q, byte_i);
          hidx_d        = hidx_q + 2'd1;
          if (hidx_q == 2'd3) begin
            phase_d = PH_HCRC;
          end
        end
        PH_HCRC: begin
          hbad_d  = (hcrc_q != byte_i);
          pos_d   = '0;
          crc_d   = '0;
          phase_d = (blen == '0) ? PH_DCRC : PH_BODY;
        end
        PH_BODY: begin
          for (int i = 0; i < CapDepth; i++) begin
            if (pos_q == PosW'(i) && pos_q < {1'b0, dlen}) begin
              cap_d[i] = byte_i;
            end
          end
          crc_d = crc8_byte(crc_q, byte_i);
          pos_d = pos_inc;
          if (pos_inc >= blen) begin
            phase_d = PH_DCRC;
          end
        end
        PH_DCRC: begin
          done_o  = 1'b1;
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    frame_o.ptype   = hdr_q[3];
    frame_o.dlen    = dlen;
    frame_o.olen    = hdr_q[2];
    frame_o.cap     = cap_q;
    frame_o.crc_ok  = (byte_i == crc_q);
    frame_o.hdr_bad = hbad_q;
  end

endmodule
`default_nettype wire

// ===== sv/srx_decode.sv =====
// Result builder: packet kind, telegram fields and status from a closed frame.
`default_nettype none
module srx_decode (
  input  wire srx_pkg::srx_frame_t frame_i,
  input  wire srx_pkg::srx_cfg_t   cfg_i,
  output srx_pkg::srx_result_t     result_o
);
  import srx_pkg::*;

  logic       radio;
  logic       teach;
  logic [7:0] hdr;
  logic [8:1][7:0] sel;   // data bytes 1..8, shifted by two for teach-in

  assign radio = (frame_i.ptype == cfg_i.radio) || (frame_i.ptype == cfg_i.erp2);
  assign hdr   = radio ? frame_i.cap[0] : 8'h00;
  assign teach = (hdr == HdrTeachIn);

  always_comb begin
    for (int k = 1; k <= 8; k++) begin
      sel[k] = teach ? frame_i.cap[k+2] : frame_i.cap[k];
    end
  end

  always_comb begin
    result_o.packet_type     = frame_i.ptype;
    result_o.data_length     = frame_i.dlen;
    result_o.option_length   = frame_i.olen;
    result_o.is_radio        = radio;
    result_o.is_response     = (frame_i.ptype == cfg_i.resp);
    result_o.response_code   = frame_i.cap[0];
    result_o.telegram_header = hdr;
    result_o.sender_id       = '0;
    result_o.payload         = '0;
    result_o.status          = StOk;
    if (radio) begin
      result_o.sender_id = {sel[1], sel[2], sel[3], sel[4]};
      if (hdr == HdrRps || hdr == Hdr1bs || hdr == HdrVld) begin
        // low nibble in data0, top bit in data3
        result_o.payload = {7'b0, sel[5][7], 16'b0, sel[5] & NibbleMask};
      end else if (hdr == Hdr4bs || hdr == HdrTeachIn) begin
        result_o.payload = {sel[8], sel[7], sel[6], sel[5]};
      end else begin
        result_o.status = StUnknown;
      end
    end
    if (!frame_i.crc_ok) begin
      result_o.status = StDataCrc;
    end
    if (frame_i.hdr_bad) begin
      result_o.status = StHdrCrc;
    end
  end

endmodule
`default_nettype wire

// ===== sv/serial_packet_receiver_crc8.sv =====
// Top level: serial packet receiver with header and data CRC-8 checks.
// Usage:
//   s_axis carries one received serial byte per item (tdata[7:0] = rx_byte).
//   The block hunts for the 0x55 sync byte, takes four header bytes and the
//   header CRC, then the data and option bytes and the closing data CRC.
//   m_axis carries one item per frame, issued for the closing CRC byte.
//   Every input byte is handled in the cycle it is accepted; the frame state
//   updates at that edge and the result is registered, so a result appears on
//   m_axis in the cycle after its closing byte is accepted.
//   Throughput is one byte per cycle while s_axis_tready_o is high; the CRC-8 step is a single-byte update.
//   The result register is the only buffer: s_axis_tready_o is high while it
//   is empty or being drained, so if the sink stalls with a result pending
//   input stops until the result is taken.
//   Reset (rst_ni low, asynchronous) returns to sync hunt, clears the captured
//   data bytes and loads the type codes with 1 (radio), 10 (ERP2), 2 (response).
//   Config: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 radio code, 1 ERP2 radio code, 2 response code); index 3 is ignored.
//   Write config only while no frame is in progress.
`default_nettype none
module serial_packet_receiver_crc8 (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire logic [7:0]                 s_axis_tdata_i,  // [7:0] rx_byte
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  // [1:0] status, [9:2] packet_type, [25:10] data_length,
  // [33:26] option_length, [34] is_radio, [35] is_response,
  // [43:36] response_code, [51:44] telegram_header, [83:52] sender_id,
  // [115:84] payload, [119:116] zero
  output logic [srx_pkg::TdataW-1:0]      m_axis_tdata_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_idx_i,
  input  wire logic [7:0]                 cfg_data_i
);
  import srx_pkg::*;

  srx_cfg_t    cfg_q;
  logic        acc;
  logic        done;
  srx_frame_t  frame;
  srx_result_t result;
  srx_result_t res_q;
  logic        ovalid_q;

  // output slot free or draining this cycle
  assign s_axis_tready_o = !ovalid_q || m_axis_tready_i;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radio <= RadioReset;
      cfg_q.erp2  <= Erp2Reset;
      cfg_q.resp  <= RespReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRadio: cfg_q.radio <= cfg_data_i;
        CfgErp2:  cfg_q.erp2  <= cfg_data_i;
        CfgResp:  cfg_q.resp  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  srx_frame u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .byte_i  (s_axis_tdata_i),
    .done_o  (done),
    .frame_o (frame)
  );

  srx_decode u_decode (
    .frame_i  (frame),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (acc && done) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && done) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {{(TdataW - $bits(srx_result_t)){1'b0}}, res_q};

endmodule
`default_nettype wire
